FILE: src/orl_pkg.sv
package orl_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int DEFAULT_TAG_COUNT   = 256;
	localparam logic [15:0] DEFAULT_LIMIT = 16'd6;
	localparam logic [15:0] CNT_MAX       = 16'hFFFF;

	// operation codes of an input word
	localparam logic [1:0] OP_NEW   = 2'd0;
	localparam logic [1:0] OP_DONE  = 2'd1;
	localparam logic [1:0] OP_LIMIT = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ISSUE  = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_QUEUED = 2'd2;
	localparam logic [1:0] KIND_LIMIT  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  request_tag;
		logic [15:0] url_handle;
		logic [31:0] byte_limit;
		logic [31:0] req_timeout;
		logic [31:0] received_bytes;
		logic        transfer_ok;
		logic [15:0] new_limit;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  tag_out;
		logic [15:0] url_out;
		logic [31:0] timeout_out;
		logic        success;
		logic [31:0] delivered_bytes;
		logic [15:0] pending_count;
		logic [15:0] in_flight_count;
		logic [4:0]  queued_count;
		logic [31:0] total_started;
		logic [7:0]  last_completed_tag;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] url;
		logic [31:0] byte_limit;
		logic [31:0] timeout;
	} fifo_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       new_req;
		logic       complete;
		logic       pop;
		logic       set_limit;
		logic       emit;
		logic [1:0] kind;
		logic       last;
	} orl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       direct_issue;
		logic       pop_avail;
		logic       pop_after_done;
		logic       out_free;
	} orl_status_t;

endpackage

FILE: src/orl_stream_if.sv
interface orl_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/orl_ram.sv
module orl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/orl_ctrl.sv
module orl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  orl_pkg::orl_status_t status,
	output logic                 in_ready,
	output orl_pkg::orl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;
	localparam logic [1:0] ST_DRAIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (status.op)
					orl_pkg::OP_NEW: begin
						if (status.out_free) begin
							cmd.new_req = 1'b1;
							cmd.emit    = 1'b1;
							cmd.last    = 1'b1;
							cmd.kind    = status.direct_issue ? orl_pkg::KIND_ISSUE
								: orl_pkg::KIND_QUEUED;
							state_d     = ST_IDLE;
						end
					end
					orl_pkg::OP_DONE: begin
						if (status.out_free) begin
							cmd.complete = 1'b1;
							cmd.emit     = 1'b1;
							if (status.pop_after_done) begin
								cmd.pop  = 1'b1;
								cmd.kind = orl_pkg::KIND_ISSUE;
								state_d  = ST_REPORT;
							end else begin
								cmd.kind = orl_pkg::KIND_REPORT;
								cmd.last = 1'b1;
								state_d  = ST_IDLE;
							end
						end
					end
					orl_pkg::OP_LIMIT: begin
						cmd.set_limit = 1'b1;
						state_d       = ST_DRAIN;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_REPORT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = orl_pkg::KIND_REPORT;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.pop_avail) begin
						cmd.pop  = 1'b1;
						cmd.kind = orl_pkg::KIND_ISSUE;
					end else begin
						cmd.kind = orl_pkg::KIND_LIMIT;
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/orl_dp.sv
module orl_dp #(
	parameter int QUEUE_DEPTH = orl_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int TAG_COUNT   = orl_pkg::DEFAULT_TAG_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  orl_pkg::in_word_t    in_word,
	input  logic                 out_ready,
	input  orl_pkg::orl_cmd_t    cmd,
	output orl_pkg::orl_status_t status,
	output logic                 out_valid,
	output orl_pkg::out_word_t   out_word
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(TAG_COUNT);
	localparam int EW = $bits(orl_pkg::fifo_entry_t);

	orl_pkg::in_word_t  item_q;
	orl_pkg::out_word_t out_q;
	orl_pkg::out_word_t out_d;
	logic               out_valid_q;

	logic [15:0]   limit_q, limit_d;
	logic [PW-1:0] head_q, head_d, head_inc;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   in_flight_q, in_flight_d, in_flight_dec;
	logic [15:0]   pending_q, pending_d;
	logic [31:0]   started_q, started_d;
	logic [7:0]    last_tag_q, last_tag_d;

	logic [CW:0]   tail_sum;
	logic [PW-1:0] tail;
	logic          fifo_full;
	logic          direct_issue;
	logic          do_issue;
	logic          out_free;
	logic          ok;

	orl_pkg::fifo_entry_t fifo_wdata, fifo_rd;
	logic [EW-1:0]        fifo_rdata;
	logic [31:0]          cap;
	logic [SW-1:0]        slot_lut [256];

	// tag to slot of the byte-limit store
	for (genvar g = 0; g < 256; g++) begin : g_slot
		assign slot_lut[g] = SW'(g % TAG_COUNT);
	end

	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail      = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
		? PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
	assign head_inc  = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
	assign fifo_full = (count_q == CW'(QUEUE_DEPTH));

	assign in_flight_dec = (in_flight_q != 16'd0) ? in_flight_q - 16'd1 : in_flight_q;
	assign direct_issue  = (in_flight_q < limit_q) || fifo_full;
	assign do_issue      = (cmd.new_req && direct_issue) || cmd.pop;
	assign out_free      = !out_valid_q || out_ready;

	assign status.op             = item_q.operation;
	assign status.direct_issue   = direct_issue;
	assign status.pop_avail      = (count_q != '0) && (in_flight_q < limit_q);
	assign status.pop_after_done = (count_q != '0) && (in_flight_dec < limit_q);
	assign status.out_free       = out_free;

	// queue storage
	assign fifo_wdata.tag        = item_q.request_tag;
	assign fifo_wdata.url        = item_q.url_handle;
	assign fifo_wdata.byte_limit = item_q.byte_limit;
	assign fifo_wdata.timeout    = item_q.req_timeout;
	assign fifo_rd               = orl_pkg::fifo_entry_t'(fifo_rdata);

	orl_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (cmd.new_req && !direct_issue),
		.waddr (tail),
		.wdata (fifo_wdata),
		.re    (cmd.capture || cmd.pop),
		.raddr (cmd.pop ? head_inc : head_q),
		.rdata (fifo_rdata)
	);

	// byte limit of each issued tag
	orl_ram #(
		.WIDTH (32),
		.DEPTH (TAG_COUNT)
	) u_cap_ram (
		.clk   (clk),
		.we    (do_issue),
		.waddr (cmd.pop ? slot_lut[fifo_rd.tag] : slot_lut[item_q.request_tag]),
		.wdata (cmd.pop ? fifo_rd.byte_limit : item_q.byte_limit),
		.re    (cmd.capture),
		.raddr (slot_lut[in_word.request_tag]),
		.rdata (cap)
	);

	assign ok = item_q.transfer_ok && (item_q.received_bytes != 32'd0)
		&& ((cap == 32'd0) || (item_q.received_bytes <= cap));

	always_comb begin
		logic [15:0] fl_a;
		pending_d = pending_q;
		if (cmd.new_req && pending_q != orl_pkg::CNT_MAX) begin
			pending_d = pending_q + 16'd1;
		end
		if (cmd.complete && pending_q != 16'd0) begin
			pending_d = pending_q - 16'd1;
		end

		fl_a        = cmd.complete ? in_flight_dec : in_flight_q;
		in_flight_d = fl_a;
		if (do_issue && fl_a != orl_pkg::CNT_MAX) begin
			in_flight_d = fl_a + 16'd1;
		end

		count_d = count_q;
		if (cmd.new_req && !direct_issue) begin
			count_d = count_q + CW'(1);
		end
		if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end

		head_d     = cmd.pop ? head_inc : head_q;
		started_d  = cmd.new_req ? started_q + 32'd1 : started_q;
		last_tag_d = cmd.complete ? item_q.request_tag : last_tag_q;
		limit_d    = limit_q;
		if (cmd.set_limit) begin
			limit_d = (item_q.new_limit == 16'd0) ? 16'd1 : item_q.new_limit;
		end
	end

	always_comb begin
		out_d                    = '0;
		out_d.result_kind        = cmd.kind;
		out_d.pending_count      = pending_d;
		out_d.in_flight_count    = in_flight_d;
		out_d.queued_count       = 5'(count_d);
		out_d.total_started      = started_d;
		out_d.last_completed_tag = last_tag_d;
		out_d.last               = cmd.last;
		unique case (cmd.kind)
			orl_pkg::KIND_ISSUE: begin
				out_d.tag_out     = cmd.pop ? fifo_rd.tag : item_q.request_tag;
				out_d.url_out     = cmd.pop ? fifo_rd.url : item_q.url_handle;
				out_d.timeout_out = cmd.pop ? fifo_rd.timeout : item_q.req_timeout;
			end
			orl_pkg::KIND_REPORT: begin
				out_d.tag_out         = item_q.request_tag;
				out_d.success         = ok;
				out_d.delivered_bytes = ok ? item_q.received_bytes : 32'd0;
			end
			orl_pkg::KIND_QUEUED: begin
				out_d.tag_out = item_q.request_tag;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= orl_pkg::DEFAULT_LIMIT;
			head_q      <= '0;
			count_q     <= '0;
			in_flight_q <= '0;
			pending_q   <= '0;
			started_q   <= '0;
			last_tag_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			limit_q     <= limit_d;
			head_q      <= head_d;
			count_q     <= count_d;
			in_flight_q <= in_flight_d;
			pending_q   <= pending_d;
			started_q   <= started_d;
			last_tag_q  <= last_tag_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_word;
		end
		if (cmd.emit) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0) && (in_flight_d <= limit_q))
		else $error("pop from empty queue or past the limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && out_valid_q) |-> out_ready)
		else $error("result word overwritten before taken");

endmodule

FILE: src/outstanding_request_limiter.sv
// Outstanding request limiter. Keeps requests in flight at or below a
// concurrency limit (6 after reset) and holds the surplus in a queue of
// QUEUE_DEPTH entries; a new request meeting a full queue is issued anyway.
// Each input word with a used operation code gives one or more result
// words, the final one marked by last. A new request is accepted, then
// executed into the output register; a completion likewise, and when it
// also releases a queued request it gives the issue word first and the
// report second. A limit change is executed, then drains the queue at one
// issue word per cycle while the output is free, each pop reading the
// single-read-port queue memory, and ends with a limit word. An unused
// operation code gives no result. Result backpressure stalls each step. The
// next word is taken as soon as the previous one is done, even while its
// last result still sits in the output register. Queue and byte-limit
// memories need no clearing after reset.
module outstanding_request_limiter #(
	parameter int QUEUE_DEPTH = orl_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int TAG_COUNT   = orl_pkg::DEFAULT_TAG_COUNT
) (
	input  logic         clk,
	input  logic         arst_n,
	orl_stream_if.sink   items,
	orl_stream_if.source results
);

	orl_pkg::orl_cmd_t    cmd;
	orl_pkg::orl_status_t status;
	logic                 in_ready;

	// sequence each word: accept, execute, then issue/report/drain steps
	orl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// counters, queue, byte-limit store and the output register
	orl_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_COUNT   (TAG_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (items.payload),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status),
		.out_valid (results.valid),
		.out_word  (results.payload)
	);

	// hold ready low while a word is being worked on
	assign items.ready = in_ready;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// Operation code with no function: the block must swallow it silently
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int QDEPTH        = orl_pkg::DEFAULT_QUEUE_DEPTH;
	localparam int TAGS          = orl_pkg::DEFAULT_TAG_COUNT;
	localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on either side
	localparam int SETTLE_CYCLES = 40;    // covers the longest limit drain
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_WORDS  = 100;   // per idling phase
	localparam int REPORT_MAX    = 10;

	logic clk;
	logic arst_n;

	orl_stream_if #(.T(orl_pkg::in_word_t))  items_if ();
	orl_stream_if #(.T(orl_pkg::out_word_t)) results_if ();

	outstanding_request_limiter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	// Shadow of the limiter state, updated at every accepted input word
	logic [15:0] lim_now;
	logic [15:0] flight_cnt;
	logic [15:0] pend_cnt;
	logic [4:0]  q_count;
	int          q_head;
	logic [31:0] started_cnt;
	logic [7:0]  done_tag;
	orl_pkg::fifo_entry_t q_entries [QDEPTH];
	logic [31:0] tag_caps [TAGS];

	// Stimulus bookkeeping: which tags hold a written byte limit, and how
	// many issues of each tag still wait for their completion
	bit          tag_seen [TAGS];
	int          tag_live [TAGS];

	orl_pkg::out_word_t expected_words [$];
	orl_pkg::out_word_t step_words [$];

	// Idling controls: the rates change between phases only; hold_left counts down on receive
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_left = 0;

	int quiet_cycles     = 0;
	int words_sent       = 0;
	int results_checked  = 0;
	int fail_count       = 0;
	int mismatch_count   = 0;
	int full_issues      = 0;
	int idle_completions = 0;
	int deepest_drain    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_shadow();
		lim_now     = orl_pkg::DEFAULT_LIMIT;
		flight_cnt  = '0;
		pend_cnt    = '0;
		q_count     = '0;
		q_head      = 0;
		started_cnt = '0;
		done_tag    = '0;
		for (int t = 0; t < TAGS; t++) begin
			tag_caps[t] = '0;
			tag_seen[t] = 1'b0;
			tag_live[t] = 0;
		end
	endfunction

	// Record one result word; the counts reflect the state right now
	function automatic void note_result(logic [1:0] kind, logic [7:0] tag, logic [15:0] url,
			logic [31:0] tmo, logic ok, logic [31:0] bytes);
		orl_pkg::out_word_t r;
		r.result_kind        = kind;
		r.tag_out            = tag;
		r.url_out            = url;
		r.timeout_out        = tmo;
		r.success            = ok;
		r.delivered_bytes    = bytes;
		r.pending_count      = pend_cnt;
		r.in_flight_count    = flight_cnt;
		r.queued_count       = q_count;
		r.total_started      = started_cnt;
		r.last_completed_tag = done_tag;
		r.last               = 1'b0;
		step_words.push_back(r);
	endfunction

	function automatic void issue_request(orl_pkg::fifo_entry_t e);
		if (flight_cnt != orl_pkg::CNT_MAX)
			flight_cnt++;
		tag_caps[e.tag] = e.byte_limit;
		tag_seen[e.tag] = 1'b1;
		tag_live[e.tag]++;
		note_result(orl_pkg::KIND_ISSUE, e.tag, e.url, e.timeout, 1'b0, 32'd0);
	endfunction

	function automatic void pop_queued();
		orl_pkg::fifo_entry_t e;
		e = q_entries[q_head];
		q_head = (q_head + 1) % QDEPTH;
		q_count--;
		issue_request(e);
	endfunction

	// Work out every result word that one input word causes and append
	// them, last one marked, to the expected store
	function automatic void predict_results(orl_pkg::in_word_t w);
		orl_pkg::fifo_entry_t e;
		orl_pkg::out_word_t   r;
		logic [31:0] cap;
		logic        ok;
		int          pops;
		e.tag        = w.request_tag;
		e.url        = w.url_handle;
		e.byte_limit = w.byte_limit;
		e.timeout    = w.req_timeout;
		pops = 0;
		step_words.delete();
		case (w.operation)
			orl_pkg::OP_NEW: begin
				if (pend_cnt != orl_pkg::CNT_MAX)
					pend_cnt++;
				started_cnt++;
				// a full queue issues rather than drops
				if (flight_cnt < lim_now || q_count >= QDEPTH) begin
					if (flight_cnt >= lim_now)
						full_issues++;
					issue_request(e);
				end else begin
					q_entries[(q_head + q_count) % QDEPTH] = e;
					q_count++;
					note_result(orl_pkg::KIND_QUEUED, w.request_tag, 16'd0, 32'd0, 1'b0,
						32'd0);
				end
			end
			orl_pkg::OP_DONE: begin
				// read the byte limit before a queued word with the same tag can
				// overwrite it
				cap = tag_caps[w.request_tag];
				if (flight_cnt == 0)
					idle_completions++;
				if (pend_cnt != 0)
					pend_cnt--;
				if (flight_cnt != 0)
					flight_cnt--;
				if (tag_live[w.request_tag] > 0)
					tag_live[w.request_tag]--;
				done_tag = w.request_tag;
				if (q_count != 0 && flight_cnt < lim_now)
					pop_queued();
				ok = w.transfer_ok && w.received_bytes != 0 &&
					(cap == 0 || w.received_bytes <= cap);
				note_result(orl_pkg::KIND_REPORT, w.request_tag, 16'd0, 32'd0, ok,
					ok ? w.received_bytes : 32'd0);
			end
			orl_pkg::OP_LIMIT: begin
				lim_now = (w.new_limit == 0) ? 16'd1 : w.new_limit;
				while (q_count != 0 && flight_cnt < lim_now) begin
					pop_queued();
					pops++;
				end
				if (pops > deepest_drain)
					deepest_drain = pops;
				note_result(orl_pkg::KIND_LIMIT, 8'd0, 16'd0, 32'd0, 1'b0, 32'd0);
			end
			default: begin
			end
		endcase
		if (step_words.size() != 0) begin
			r = step_words.pop_back();
			r.last = 1'b1;
			step_words.push_back(r);
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
		end
	endfunction

	// Compare one accepted result word with the oldest expectation
	function automatic void check_result(orl_pkg::out_word_t got);
		orl_pkg::out_word_t want;
		string     bad;
		results_checked++;
		if (expected_words.size() == 0) begin
			fail_count++;
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected result word %h (kind %0d tag %0d)",
					got, got.result_kind, got.tag_out);
			return;
		end
		want = expected_words.pop_front();
		bad = "";
		if (got.result_kind !== want.result_kind)               bad = {bad, " result_kind"};
		if (got.tag_out !== want.tag_out)                       bad = {bad, " tag_out"};
		if (got.url_out !== want.url_out)                       bad = {bad, " url_out"};
		if (got.timeout_out !== want.timeout_out)               bad = {bad, " timeout_out"};
		if (got.success !== want.success)                       bad = {bad, " success"};
		if (got.delivered_bytes !== want.delivered_bytes)       bad = {bad, " delivered_bytes"};
		if (got.pending_count !== want.pending_count)           bad = {bad, " pending_count"};
		if (got.in_flight_count !== want.in_flight_count)       bad = {bad, " in_flight_count"};
		if (got.queued_count !== want.queued_count)             bad = {bad, " queued_count"};
		if (got.total_started !== want.total_started)           bad = {bad, " total_started"};
		if (got.last_completed_tag !== want.last_completed_tag) bad = {bad, " last_completed_tag"};
		if (got.last !== want.last)                             bad = {bad, " last"};
		if (bad != "") begin
			fail_count++;
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("result %0d differs in%s: expected %h, got %h",
					results_checked, bad, want, got);
		end
	endfunction

	// Receive side: check the word taken at this edge, then decide whether
	// to take the next one. A hold counts down here at every edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready)
				check_result(results_if.payload);
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_words.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one word, idling first at the phase's rate. Valid stays high
	// after acceptance so that a back-to-back word needs no second drive in
	// the same step; whoever waits next lowers it.
	task automatic send_word(orl_pkg::in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid   <= 1'b1;
		items_if.payload <= w;
		do
			@(posedge clk);
		while (!items_if.ready);
		predict_results(w);
		words_sent++;
	endtask

	// Pause the sender until every expected word is back, then let the
	// block settle
	task automatic wait_drained();
		items_if.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Fields that the operation ignores carry random noise
	function automatic orl_pkg::in_word_t noise_word(logic [1:0] op);
		orl_pkg::in_word_t w;
		w.operation      = op;
		w.request_tag    = 8'($urandom_range(255));
		w.url_handle     = 16'($urandom_range(65535));
		w.byte_limit     = $urandom;
		w.req_timeout    = $urandom;
		w.received_bytes = $urandom;
		w.transfer_ok    = 1'($urandom_range(1));
		w.new_limit      = 16'($urandom_range(65535));
		return w;
	endfunction

	function automatic orl_pkg::in_word_t mk_new(logic [7:0] tag, logic [15:0] url,
			logic [31:0] cap, logic [31:0] tmo);
		orl_pkg::in_word_t w;
		w = noise_word(orl_pkg::OP_NEW);
		w.request_tag = tag;
		w.url_handle  = url;
		w.byte_limit  = cap;
		w.req_timeout = tmo;
		return w;
	endfunction

	function automatic orl_pkg::in_word_t mk_done(logic [7:0] tag, logic [31:0] rcv,
			logic ok);
		orl_pkg::in_word_t w;
		w = noise_word(orl_pkg::OP_DONE);
		w.request_tag    = tag;
		w.received_bytes = rcv;
		w.transfer_ok    = ok;
		return w;
	endfunction

	function automatic orl_pkg::in_word_t mk_limit(logic [15:0] lim);
		orl_pkg::in_word_t w;
		w = noise_word(orl_pkg::OP_LIMIT);
		w.new_limit = lim;
		return w;
	endfunction

	// Well-formed traffic: completions name tags that were issued, mostly
	// ones still in flight, and the load is steered so the queue both fills
	// and empties
	function automatic orl_pkg::in_word_t random_word();
		orl_pkg::in_word_t w;
		int          roll;
		int          live_tags [$];
		int          seen_tags [$];
		logic [7:0]  tag;
		logic [31:0] cap;
		for (int t = 0; t < TAGS; t++) begin
			if (tag_live[t] > 0)
				live_tags.push_back(t);
			if (tag_seen[t])
				seen_tags.push_back(t);
		end
		roll = $urandom_range(99);
		if (roll < 4)
			return noise_word(OP_UNUSED);
		if (roll < 13)
			w = noise_word(orl_pkg::OP_LIMIT);
		else if (seen_tags.size() != 0 && (pend_cnt > 30 ? roll < 80 : roll < 50))
			w = noise_word(orl_pkg::OP_DONE);
		else
			w = noise_word(orl_pkg::OP_NEW);
		case (w.operation)
			orl_pkg::OP_NEW: begin
				case ($urandom_range(3))
					0: w.byte_limit = 32'd0;
					1: w.byte_limit = $urandom_range(1, 2000);
					2: w.byte_limit = 32'hFFFF_FFFF;
					default: begin
					end
				endcase
			end
			orl_pkg::OP_DONE: begin
				if (live_tags.size() != 0 && $urandom_range(99) < 85)
					tag = 8'(live_tags[$urandom_range(live_tags.size() - 1)]);
				else
					tag = 8'(seen_tags[$urandom_range(seen_tags.size() - 1)]);
				cap = tag_caps[tag];
				w.request_tag = tag;
				w.transfer_ok = ($urandom_range(99) < 85);
				case ($urandom_range(5))
					0: w.received_bytes = 32'd0;
					1: w.received_bytes = cap;
					2: w.received_bytes = cap + 32'd1;
					3: w.received_bytes = cap - 32'd1;
					4: w.received_bytes = $urandom_range(1, 3000);
					default: begin
					end
				endcase
			end
			default: begin
				case ($urandom_range(9))
					0: w.new_limit = 16'd0;
					1: w.new_limit = 16'hFFFF;
					2: w.new_limit = 16'($urandom_range(65535));
					default: w.new_limit = 16'($urandom_range(1, 8));
				endcase
			end
		endcase
		return w;
	endfunction

	// Issue, complete, then complete the same tag again with nothing in
	// flight: counts hold at zero and the report still comes
	task automatic test_idle_completion();
		send_word(mk_new(8'h80, 16'h1234, 32'd0, 32'd7));
		send_word(mk_done(8'h80, 32'd1, 1'b1));
		send_word(mk_done(8'h80, 32'hFFFF_FFFF, 1'b1));
	endtask

	// Limit of zero clamps to one; fill the queue, then overflow issues
	task automatic test_queue_full_issue();
		send_word(mk_limit(16'd0));
		send_word(mk_new(8'h00, 16'h0000, 32'd5, 32'd0));
		// same tag as the one in flight, opposite extremes
		send_word(mk_new(8'h00, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (int t = 1; t < QDEPTH; t++)
			send_word(mk_new(8'(t), 16'($urandom_range(65535)), $urandom_range(1, 100), $urandom));
		send_word(mk_new(8'hFF, 16'hA5A5, 32'd0, 32'h5A5A_5A5A));
	endtask

	// Completing tag 0 releases the queued tag 0; the report must still use
	// the old byte limit of 5
	task automatic test_tag_reuse();
		send_word(mk_done(8'hFF, 32'd1, 1'b0));
		send_word(mk_done(8'h00, 32'd5, 1'b1));
	endtask

	task automatic test_unknown_op();
		send_word(noise_word(OP_UNUSED));
	endtask

	// Widest limit drains the whole queue in one go, then check byte limits
	task automatic test_limit_drain();
		send_word(mk_limit(16'hFFFF));
		send_word(mk_done(8'h00, 32'hFFFF_FFFF, 1'b1));
		send_word(mk_done(8'h01, 32'd0, 1'b1));
		wait_drained();
	endtask

	// Hold the receiver off while the sender keeps offering, so the block
	// backs up into its input
	task automatic test_backpressure_hold();
		idle_pct  = 0;
		stall_pct = 0;
		send_word(mk_limit(16'd2));
		hold_left = HOLD_CYCLES;
		repeat (40) send_word(random_word());
		wait_drained();
	endtask

	task automatic test_random_traffic(int send_idle, int recv_stall, int count);
		orl_pkg::in_word_t w;
		int       moved;
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		moved = 0;
		while (moved < count) begin
			w = random_word();
			send_word(w);
			if (w.operation != OP_UNUSED)
				moved++;
		end
		wait_drained();
	endtask

	initial begin
		arst_n           <= 1'b0;
		items_if.valid   <= 1'b0;
		items_if.payload <= '0;
		reset_shadow();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_completion();
		test_queue_full_issue();
		test_tag_reuse();
		test_unknown_op();
		test_limit_drain();
		test_backpressure_hold();
		test_random_traffic(0, 0, RANDOM_WORDS);
		test_random_traffic(79, 0, RANDOM_WORDS);
		test_random_traffic(0, 79, RANDOM_WORDS);
		test_random_traffic(24, 24, RANDOM_WORDS);

		$display("covered %0d input words and %0d result words, %0d mismatches",
			words_sent, results_checked, mismatch_count);
		$display("seen: %0d issues past a full queue, %0d idle completions, deepest drain %0d",
			full_issues, idle_completions, deepest_drain);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
